// ===== design/assert_macros.svh =====
// Shared assertion macros for the key event encoder checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge, suspended while reset is held.
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/kettb_pkg.sv =====
package kettb_pkg;

  // Widths of the item fields
  localparam int KEY_W   = 5;
  localparam int CP_W    = 21;
  localparam int BYTE_W  = 8;
  localparam int MODS_W  = 3;
  localparam int FLAGS_W = 5;

  // Packed stream widths
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 24;

  // Number of keys with an escape sequence in the table
  localparam int SEQUENCE_KEYS = 22;

  // Dense key codes of the modifier keys
  localparam logic [KEY_W-1:0] KEY_LALT   = 5'd23;
  localparam logic [KEY_W-1:0] KEY_RCTRL  = 5'd27;

  // Configuration register indexes
  localparam logic CFG_READ_ENABLED = 1'b0;
  localparam logic CFG_NATIVE_TERM  = 1'b1;

  // Result kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_CP   = 1'b1;

  // Characters used by the encoder
  localparam logic [BYTE_W-1:0] CH_ESC = 8'd27;
  localparam logic [CP_W-1:0] CP_NUL   = 21'd0;
  localparam logic [CP_W-1:0] CP_BS    = 21'd8;
  localparam logic [CP_W-1:0] CP_LF    = 21'd10;
  localparam logic [CP_W-1:0] CP_CR    = 21'd13;
  localparam logic [CP_W-1:0] CP_SPACE = 21'd32;
  localparam logic [CP_W-1:0] CP_QMARK = 21'd63;
  localparam logic [CP_W-1:0] CP_AT    = 21'd64;
  localparam logic [CP_W-1:0] CP_USCORE = 21'd95;
  localparam logic [CP_W-1:0] CP_BTICK = 21'd96;
  localparam logic [CP_W-1:0] CP_RBRACE = 21'd125;
  localparam logic [CP_W-1:0] CP_DEL   = 21'd127;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One escape sequence table entry
  typedef struct packed {
    logic [4:0][BYTE_W-1:0] bytes;
    logic [2:0]             len;
    logic                   one_if_mod;
    logic                   o_short;
  } seq_entry_t;

  // Work for one key event, handed from front to back
  typedef struct packed {
    logic              seq_valid;
    logic [KEY_W-1:0]  seq_idx;
    logic [MODS_W-1:0] mods;
    logic              cp_valid;
    logic              cp_kind;
    logic [CP_W-1:0]   cp_value;
  } desc_t;

  // Escape sequence table, in key code order starting at key code one
  function automatic seq_entry_t seq_rom(logic [KEY_W-1:0] idx);
    seq_entry_t e;
    e = '0;
    case (idx)
      5'd0:  e = '{bytes: {8'd0, 8'd0, "A", "[", CH_ESC}, len: 3'd3, one_if_mod: 1'b1, o_short: 1'b0};
      5'd1:  e = '{bytes: {8'd0, 8'd0, "B", "[", CH_ESC}, len: 3'd3, one_if_mod: 1'b1, o_short: 1'b0};
      5'd2:  e = '{bytes: {8'd0, 8'd0, "C", "[", CH_ESC}, len: 3'd3, one_if_mod: 1'b1, o_short: 1'b0};
      5'd3:  e = '{bytes: {8'd0, 8'd0, "D", "[", CH_ESC}, len: 3'd3, one_if_mod: 1'b1, o_short: 1'b0};
      5'd4:  e = '{bytes: {8'd0, 8'd0, "F", "[", CH_ESC}, len: 3'd3, one_if_mod: 1'b1, o_short: 1'b0};
      5'd5:  e = '{bytes: {8'd0, 8'd0, "H", "[", CH_ESC}, len: 3'd3, one_if_mod: 1'b1, o_short: 1'b0};
      5'd6:  e = '{bytes: {8'd0, "~", "2", "[", CH_ESC}, len: 3'd4, one_if_mod: 1'b0, o_short: 1'b0};
      5'd7:  e = '{bytes: {8'd0, "~", "3", "[", CH_ESC}, len: 3'd4, one_if_mod: 1'b0, o_short: 1'b0};
      5'd8:  e = '{bytes: {8'd0, "~", "5", "[", CH_ESC}, len: 3'd4, one_if_mod: 1'b0, o_short: 1'b0};
      5'd9:  e = '{bytes: {8'd0, "~", "6", "[", CH_ESC}, len: 3'd4, one_if_mod: 1'b0, o_short: 1'b0};
      5'd10: e = '{bytes: {8'd0, "P", "1", "[", CH_ESC}, len: 3'd4, one_if_mod: 1'b0, o_short: 1'b1};
      5'd11: e = '{bytes: {8'd0, "Q", "1", "[", CH_ESC}, len: 3'd4, one_if_mod: 1'b0, o_short: 1'b1};
      5'd12: e = '{bytes: {8'd0, "R", "1", "[", CH_ESC}, len: 3'd4, one_if_mod: 1'b0, o_short: 1'b1};
      5'd13: e = '{bytes: {8'd0, "S", "1", "[", CH_ESC}, len: 3'd4, one_if_mod: 1'b0, o_short: 1'b1};
      5'd14: e = '{bytes: {"~", "5", "1", "[", CH_ESC}, len: 3'd5, one_if_mod: 1'b0, o_short: 1'b0};
      5'd15: e = '{bytes: {"~", "7", "1", "[", CH_ESC}, len: 3'd5, one_if_mod: 1'b0, o_short: 1'b0};
      5'd16: e = '{bytes: {"~", "8", "1", "[", CH_ESC}, len: 3'd5, one_if_mod: 1'b0, o_short: 1'b0};
      5'd17: e = '{bytes: {"~", "9", "1", "[", CH_ESC}, len: 3'd5, one_if_mod: 1'b0, o_short: 1'b0};
      5'd18: e = '{bytes: {"~", "0", "2", "[", CH_ESC}, len: 3'd5, one_if_mod: 1'b0, o_short: 1'b0};
      5'd19: e = '{bytes: {"~", "1", "2", "[", CH_ESC}, len: 3'd5, one_if_mod: 1'b0, o_short: 1'b0};
      5'd20: e = '{bytes: {"~", "3", "2", "[", CH_ESC}, len: 3'd5, one_if_mod: 1'b0, o_short: 1'b0};
      5'd21: e = '{bytes: {"~", "4", "2", "[", CH_ESC}, len: 3'd5, one_if_mod: 1'b0, o_short: 1'b0};
      default: e = '0;
    endcase
    return e;
  endfunction

  // Number of bytes a table key emits with the given modifier parameter
  function automatic logic [2:0] seq_count(seq_entry_t e, logic [MODS_W-1:0] mods);
    logic [2:0] body;
    logic [2:0] one;
    logic [2:0] semi;
    body = e.len - 3'd1;
    one  = {2'b00, e.one_if_mod && (mods != '0)};
    semi = (mods != '0) ? 3'd2 : 3'd0;
    if (e.o_short && (mods == '0)) begin
      return 3'd3;
    end
    return body + one + semi + 3'd1;
  endfunction

  // Byte at a position of a table key's sequence
  function automatic logic [BYTE_W-1:0] seq_byte(seq_entry_t e, logic [MODS_W-1:0] mods,
                                                 logic [2:0] pos);
    logic [2:0]        body;
    logic [2:0]        one;
    logic [BYTE_W-1:0] fin;
    body = e.len - 3'd1;
    one  = {2'b00, e.one_if_mod && (mods != '0)};
    fin  = e.bytes[body];
    if (e.o_short && (mods == '0)) begin
      case (pos)
        3'd0:    return CH_ESC;
        3'd1:    return "O";
        default: return fin;
      endcase
    end else if (pos < body) begin
      return e.bytes[pos];
    end else if (pos < body + one) begin
      return "1";
    end else if ((mods != '0) && (pos == body + one)) begin
      return ";";
    end else if ((mods != '0) && (pos == body + one + 3'd1)) begin
      return 8'("1") + {5'b00000, mods};
    end
    return fin;
  endfunction

endpackage

// ===== design/kettb_front.sv =====
module kettb_front
  import kettb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic                 cfg_data,
  input  logic                 q_full,
  output logic                 push,
  output desc_t                push_desc
);

  logic               read_enabled;
  logic               native_term_mode;
  logic [FLAGS_W-1:0] modifier_flags;
  logic [FLAGS_W-1:0] modifier_flags_next;

  logic [KEY_W-1:0] key;
  logic [CP_W-1:0]  cp;
  logic [CP_W-1:0]  cp_fix;
  logic             release_key;
  logic             accept;
  logic             control;

  assign key         = s_tdata[KEY_W-1:0];
  assign cp          = s_tdata[KEY_W +: CP_W];
  assign release_key = s_tuser;
  assign s_tready    = !q_full;
  assign cfg_ready   = 1'b1;
  assign accept      = s_tvalid && s_tready;

  // Update the modifier bits from this word's key
  always_comb begin
    modifier_flags_next = modifier_flags;
    if (key >= KEY_LALT && key <= KEY_RCTRL) begin
      modifier_flags_next[3'(key - KEY_LALT)] = !release_key;
    end
  end

  // Classify the word into work for the back end
  always_comb begin
    control             = |modifier_flags_next[4:3];
    push_desc           = '0;
    push_desc.mods      = {control, modifier_flags_next[0], |modifier_flags_next[2:1]};
    push_desc.seq_valid = !release_key && key >= 5'd1 && key <= 5'(SEQUENCE_KEYS);
    push_desc.seq_idx   = key - 5'd1;

    cp_fix = (cp == CP_LF) ? CP_CR : cp;
    if (!native_term_mode && cp_fix == CP_BS) begin
      cp_fix = CP_DEL;
    end

    push_desc.cp_valid = (cp != CP_NUL);
    push_desc.cp_kind  = KIND_BYTE;
    if (control && cp_fix == CP_SPACE) begin
      push_desc.cp_value = CP_NUL;
    end else if (control && cp_fix inside {[CP_BTICK:CP_RBRACE]}) begin
      push_desc.cp_value = cp_fix - CP_BTICK;
    end else if (control && cp_fix inside {[CP_AT:CP_USCORE]}) begin
      push_desc.cp_value = cp_fix - CP_AT;
    end else if (control && cp_fix == CP_QMARK) begin
      push_desc.cp_value = CP_DEL;
    end else begin
      push_desc.cp_kind  = KIND_CP;
      push_desc.cp_value = cp_fix;
    end

    push = accept && read_enabled && (push_desc.seq_valid || push_desc.cp_valid);
  end

  // Hold modifier state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      modifier_flags   <= '0;
      read_enabled     <= 1'b1;
      native_term_mode <= 1'b0;
    end else begin
      if (accept) begin
        modifier_flags <= modifier_flags_next;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_READ_ENABLED: read_enabled     <= cfg_data;
          CFG_NATIVE_TERM:  native_term_mode <= cfg_data;
          default:          read_enabled     <= read_enabled;
        endcase
      end
    end
  end

endmodule

// ===== design/kettb_queue.sv =====
module kettb_queue
  import kettb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_desc,
  output logic  full,
  output logic  q_valid,
  output desc_t q_desc,
  input  logic  q_pop
);

  desc_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_desc  = entries[rd_ptr];

  // Store pushed work
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/kettb_back.sv =====
module kettb_back
  import kettb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  desc_t                q_desc,
  output logic                 q_pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tuser,
  output logic                 m_tlast
);

  logic [2:0]      pos;
  logic [2:0]      pos_next;
  seq_entry_t      entry;
  logic [2:0]      nseq;
  logic [3:0]      total;
  logic            advance;
  logic            is_last;
  logic            kind;
  logic [CP_W-1:0] value;

  assign advance = !m_tvalid || m_tready;

  // Pick the word for the current position of the head event
  always_comb begin
    entry   = seq_rom(q_desc.seq_idx);
    nseq    = q_desc.seq_valid ? seq_count(entry, q_desc.mods) : 3'd0;
    total   = {1'b0, nseq} + {3'b000, q_desc.cp_valid};
    is_last = ({1'b0, pos} == total - 4'd1);
    if (pos < nseq) begin
      kind  = KIND_BYTE;
      value = {13'd0, seq_byte(entry, q_desc.mods, pos)};
    end else begin
      kind  = q_desc.cp_kind;
      value = q_desc.cp_value;
    end
    q_pop    = advance && q_valid && is_last;
    pos_next = pos;
    if (advance && q_valid) begin
      pos_next = is_last ? 3'd0 : pos + 3'd1;
    end
  end

  // Advance the position within the event
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

  // Load the output register whenever it is free or being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && q_valid) begin
      m_tdata <= {{(M_TDATA_W-CP_W){1'b0}}, value};
      m_tuser <= kind;
      m_tlast <= is_last;
    end
  end

endmodule

// ===== design/key_event_to_terminal_bytes_top.sv =====
// Channel  Dir  Handshake            Payload
// s_*      in   s_tvalid/s_tready    tdata: key_code, code_point; tuser: key_release
// m_*      out  m_tvalid/m_tready    tdata: value; tuser: kind; tlast: last
// cfg_*    in   cfg_valid/cfg_ready  cfg_index (0 read_enabled, 1 native_term_mode), cfg_data
//
// An event is classified as it is accepted, then held in the work queue and then in the output register.
// The back end sends one word a cycle while the output is not stalled, 0 to 8 per event (an event with no words is
// never queued); the sequence position counter sets this figure.
// A two-entry work queue lets input keep flowing while output stalls; s_tready
// drops only when both entries are taken. cfg_ready is always high.
// Reset (rst, synchronous) clears modifiers and queue, sets read_enabled to 1.
module key_event_to_terminal_bytes_top
  import kettb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // [4:0] key_code, [25:5] code_point, zero above
  input  logic                 s_tuser,  // [0] key_release
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,  // [20:0] value, zero above
  output logic                 m_tuser,  // [0] kind
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic                 cfg_data
);

  logic  push;
  desc_t push_desc;
  logic  q_full;
  logic  q_valid;
  desc_t q_desc;
  logic  q_pop;

  kettb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  kettb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_desc    (q_desc),
    .q_pop     (q_pop)
  );

  kettb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_desc   (q_desc),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== design/kettb_checker.sv =====
`include "assert_macros.svh"

module kettb_checker
  import kettb_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tuser,
  input logic                 m_tlast
);

  logic                 out_stall;
  logic [M_TDATA_W+1:0] out_word;
  logic                 out_high_zero;

  assign out_stall     = m_tvalid && !m_tready;
  assign out_word      = {m_tlast, m_tuser, m_tdata};
  assign out_high_zero = (m_tdata[M_TDATA_W-1:BYTE_W] == '0);

  // A stalled output word holds
  `CHK_ASSERT(a_out_hold, clk, rst, out_stall |=> m_tvalid && $stable(out_word), "word moved")

  // A code point word always closes its event
  `CHK_ASSERT(a_cp_last, clk, rst, m_tvalid && m_tuser |-> m_tlast, "code point not last")

  // Raw terminal words carry a single byte
  `CHK_ASSERT(a_byte_range, clk, rst, m_tvalid && !m_tuser |-> out_high_zero, "raw word above 255")

  // Reset empties the output
  `CHK_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_tvalid, "output valid after reset")

endmodule

bind key_event_to_terminal_bytes_top kettb_checker u_kettb_checker (.*);
